// File: rtl/mefr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mefr_pkg
// Shared types and constants for the escape-framed meter frame receiver.
// ----------------------------------------------------------------------------
package mefr_pkg;

	localparam int MAX_LEN = 512;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int LEN_W   = 10;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic [7:0] ESC_BYTE  = 8'h1b;
	localparam logic [7:0] END_BYTE  = 8'h1a;
	localparam logic [7:0] VER_ONE   = 8'h01;
	localparam logic [7:0] VER_TWO   = 8'h02;
	localparam logic [1:0] RUN_LAST  = 2'd3;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_VERSION = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_TRAILER = 2'd3
	} phase_t;

	// One queued command: a frame-done marker, or up to three flushed
	// escapes optionally followed by one received byte.
	typedef struct packed {
		logic             is_done;
		logic [1:0]       num_esc;
		logic             emit_byte;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic [1:0]       version;
		logic             ovf;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/mefr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mefr_front
// Frame tracker: classifies each received byte and queues output commands.
// ----------------------------------------------------------------------------
module mefr_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              byte_valid,
	input  wire [7:0]        rx_byte,
	output logic             push,
	output mefr_pkg::cmd_t   push_cmd
);
	import mefr_pkg::*;

	phase_t           phase_q, phase_d;
	logic [1:0]       begin_cnt_q, begin_cnt_d;
	logic [1:0]       version_q, version_d;
	logic [1:0]       vcnt_q, vcnt_d;
	logic [1:0]       pend_q, pend_d;
	logic [1:0]       trl_q, trl_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             ovf_q, ovf_d;

	logic [CNT_W-1:0] remaining;
	logic [2:0]       need;
	logic [2:0]       kept;
	logic             is_esc;

	assign is_esc    = (rx_byte == ESC_BYTE);
	assign remaining = CNT_W'(MAX_LEN) - count_q;
	assign need      = {1'b0, pend_q} + 3'd1;
	assign kept      = (remaining >= CNT_W'(need)) ? need : remaining[2:0];

	// Next state
	always_comb begin
		phase_d     = phase_q;
		begin_cnt_d = begin_cnt_q;
		version_d   = version_q;
		vcnt_d      = vcnt_q;
		pend_d      = pend_q;
		trl_d       = trl_q;
		count_d     = count_q;
		ovf_d       = ovf_q;
		if (byte_valid) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (!is_esc) begin
						begin_cnt_d = 2'd0;
					end else if (begin_cnt_q == RUN_LAST) begin
						begin_cnt_d = 2'd0;
						phase_d     = PH_VERSION;
						vcnt_d      = 2'd0;
					end else begin
						begin_cnt_d = begin_cnt_q + 2'd1;
					end
				end
				PH_VERSION: begin
					if (vcnt_q == 2'd0) begin
						if (rx_byte == VER_ONE || rx_byte == VER_TWO) begin
							version_d = rx_byte[1:0];
							vcnt_d    = 2'd1;
						end else begin
							phase_d     = PH_HUNT;
							begin_cnt_d = 2'd0;
						end
					end else if (rx_byte == {6'd0, version_q}) begin
						if (vcnt_q == RUN_LAST) begin
							phase_d = PH_PAYLOAD;
							pend_d  = 2'd0;
							count_d = '0;
							ovf_d   = 1'b0;
						end else begin
							vcnt_d = vcnt_q + 2'd1;
						end
					end else begin
						phase_d     = PH_HUNT;
						begin_cnt_d = 2'd0;
					end
				end
				PH_PAYLOAD: begin
					if (is_esc) begin
						if (pend_q == RUN_LAST) begin
							phase_d = PH_TRAILER;
							trl_d   = 2'd0;
							pend_d  = 2'd0;
						end else begin
							pend_d = pend_q + 2'd1;
						end
					end else begin
						// Whatever does not fit below the limit is dropped.
						count_d = count_q + CNT_W'(kept);
						ovf_d   = ovf_q | (kept != need);
						pend_d  = 2'd0;
					end
				end
				PH_TRAILER: begin
					if (trl_q == 2'd0) begin
						if (rx_byte == END_BYTE) begin
							trl_d = 2'd1;
						end else begin
							phase_d     = PH_HUNT;
							begin_cnt_d = 2'd0;
						end
					end else if (trl_q != RUN_LAST) begin
						trl_d = trl_q + 2'd1;
					end else begin
						trl_d       = 2'd0;
						phase_d     = PH_HUNT;
						begin_cnt_d = 2'd0;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	// Command output
	always_comb begin
		push               = 1'b0;
		push_cmd.is_done   = 1'b0;
		push_cmd.num_esc   = (kept > {1'b0, pend_q}) ? pend_q : kept[1:0];
		push_cmd.emit_byte = (kept == need);
		push_cmd.data      = rx_byte;
		push_cmd.len       = LEN_W'(count_q);
		push_cmd.version   = version_q;
		push_cmd.ovf       = ovf_q;
		if (byte_valid && phase_q == PH_PAYLOAD) begin
			if (is_esc) begin
				push             = (pend_q == RUN_LAST);
				push_cmd.is_done = 1'b1;
			end else begin
				push = (kept != 3'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			begin_cnt_q <= 2'd0;
			version_q   <= 2'd0;
			vcnt_q      <= 2'd0;
			pend_q      <= 2'd0;
			trl_q       <= 2'd0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			begin_cnt_q <= begin_cnt_d;
			version_q   <= version_d;
			vcnt_q      <= vcnt_d;
			pend_q      <= pend_d;
			trl_q       <= trl_d;
			count_q     <= count_d;
			ovf_q       <= ovf_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/mefr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mefr_queue
// Short command queue between the frame tracker and the beat generator.
// ----------------------------------------------------------------------------
module mefr_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  mefr_pkg::cmd_t   push_cmd,
	input  wire              pop,
	output mefr_pkg::cmd_t   head,
	output logic             empty,
	output logic             full
);
	import mefr_pkg::*;

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (QPTR_W + 1)'(QDEPTH));
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/mefr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mefr_back
// Beat generator: expands queued commands into registered output beats.
// ----------------------------------------------------------------------------
module mefr_back (
	input  wire              clk,
	input  wire              arst_n,
	input  mefr_pkg::cmd_t   head,
	input  wire              empty,
	output logic             pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic             out_kind,
	output logic             out_last,
	output logic [7:0]       out_byte,
	output logic [9:0]       out_len,
	output logic [1:0]       out_version,
	output logic             out_ovf
);
	import mefr_pkg::*;

	logic [1:0]       esc_idx_q;
	logic             valid_q;
	logic             kind_q, last_q, ovf_q;
	logic [7:0]       byte_q;
	logic [LEN_W-1:0] len_q;
	logic [1:0]       version_q;

	logic             load;
	logic             beat_kind, beat_last, beat_ovf;
	logic [7:0]       beat_byte;
	logic [LEN_W-1:0] beat_len;
	logic             in_esc;

	assign load   = !valid_q || out_ready;
	assign in_esc = (esc_idx_q < head.num_esc);
	assign pop    = load && !empty && beat_last;

	always_comb begin
		beat_kind = 1'b0;
		beat_byte = head.data;
		beat_len  = '0;
		beat_ovf  = 1'b0;
		beat_last = 1'b1;
		if (head.is_done) begin
			beat_kind = 1'b1;
			beat_byte = 8'd0;
			beat_len  = head.len;
			beat_ovf  = head.ovf;
		end else if (in_esc) begin
			beat_byte = ESC_BYTE;
			beat_last = !head.emit_byte && ((esc_idx_q + 2'd1) == head.num_esc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			esc_idx_q <= 2'd0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				esc_idx_q <= beat_last ? 2'd0 : esc_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			kind_q    <= beat_kind;
			last_q    <= beat_last;
			byte_q    <= beat_byte;
			len_q     <= beat_len;
			version_q <= head.version;
			ovf_q     <= beat_ovf;
		end
	end

	assign out_valid   = valid_q;
	assign out_kind    = kind_q;
	assign out_last    = last_q;
	assign out_byte    = byte_q;
	assign out_len     = len_q;
	assign out_version = version_q;
	assign out_ovf     = ovf_q;

endmodule
`default_nettype wire

// File: rtl/meter_escape_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meter_escape_frame_receiver_unit
// Recovers escape-framed meter frames from a stream of received bytes.
// ----------------------------------------------------------------------------
// Path: the command for a result beat enters the queue at the edge that accepts
// the byte causing it; the beat generator then loads it into the output register.
// Throughput: one byte per cycle unless the 4-entry command queue is full; a
// byte that flushes held escapes causes up to four beats, one per ready cycle.
// Reset: arst_n clears the frame tracker, the queue and the output register;
// the block hunts for a frame start afterwards.
// ----------------------------------------------------------------------------
module meter_escape_frame_receiver_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [17:8] frame_length,
	                               // [19:18] frame_version, [20] overflowed
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast    // last_of_run
);
	import mefr_pkg::*;

	cmd_t       push_cmd, head;
	logic       push, pop, empty, full;
	logic [7:0] out_byte;
	logic [9:0] out_len;
	logic [1:0] out_version;
	logic       out_ovf;

	assign s_tready = !full;

	mefr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid && s_tready),
		.rx_byte    (s_tdata),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	mefr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	mefr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_last    (m_tlast),
		.out_byte    (out_byte),
		.out_len     (out_len),
		.out_version (out_version),
		.out_ovf     (out_ovf)
	);

	assign m_tdata = {3'd0, out_ovf, out_version, out_len, out_byte};

endmodule
`default_nettype wire

// File: bench/mefr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mefr_checker
// Watches both stream channels of the frame receiver. Every byte taken on the
// input side is run through a cycle-free model of the deframer, and the result
// beats that it calls for are queued. Every beat leaving the block is compared
// field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module mefr_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [23:0] m_tdata,
	input  wire         m_tuser,
	input  wire         m_tlast,
	output int          mismatches,
	output int          outstanding,
	output int          beats_checked,
	output int          frames_closed,
	output int          bytes_taken
);
	import mefr_pkg::*;

	localparam int RUN_LEN       = int'(RUN_LAST) + 1;
	localparam int TRAILER_BYTES = 3;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic [1:0]       version;
		logic             ovf;
		logic             last;
	} result_beat_t;

	result_beat_t due_beats[$];
	result_beat_t byte_beats[RUN_LEN];
	int           byte_beat_count;

	phase_t       phase_now     = PH_HUNT;
	int           start_escapes = 0;
	logic [1:0]   hdr_version   = '0;
	int           hdr_matches   = 0;
	int           held_escapes  = 0;
	int           trailer_seen  = 0;
	int           kept_bytes    = 0;
	logic         dropped       = 1'b0;

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		beats_checked = 0;
		frames_closed = 0;
		bytes_taken   = 0;
	end

	task automatic restart_hunt();
		phase_now     = PH_HUNT;
		start_escapes = 0;
	endtask

	task automatic keep_payload(input logic [7:0] b);
		result_beat_t r;
		if (kept_bytes < MAX_LEN) begin
			kept_bytes++;
			r         = '0;
			r.data    = b;
			r.version = hdr_version;
			byte_beats[byte_beat_count] = r;
			byte_beat_count++;
		end else begin
			dropped = 1'b1;
		end
	endtask

	// Advances the frame tracker by one received byte and queues the beats
	// that the byte causes, the final one marked as last.
	task automatic deframe_byte(input logic [7:0] b);
		result_beat_t r;
		int           i;
		byte_beat_count = 0;
		case (phase_now)
			PH_HUNT: begin
				if (b == ESC_BYTE) begin
					start_escapes++;
					if (start_escapes >= RUN_LEN) begin
						phase_now   = PH_VERSION;
						hdr_matches = 0;
					end
				end else begin
					start_escapes = 0;
				end
			end
			PH_VERSION: begin
				if (hdr_matches == 0) begin
					if (b == VER_ONE || b == VER_TWO) begin
						hdr_version = b[1:0];
						hdr_matches = 1;
					end else begin
						restart_hunt();
					end
				end else if (b == {6'b0, hdr_version}) begin
					hdr_matches++;
					if (hdr_matches >= RUN_LEN) begin
						phase_now    = PH_PAYLOAD;
						held_escapes = 0;
						kept_bytes   = 0;
						dropped      = 1'b0;
					end
				end else begin
					restart_hunt();
				end
			end
			PH_PAYLOAD: begin
				if (b == ESC_BYTE) begin
					held_escapes++;
					if (held_escapes >= RUN_LEN) begin
						r         = '0;
						r.kind    = 1'b1;
						r.len     = LEN_W'(kept_bytes);
						r.version = hdr_version;
						r.ovf     = dropped;
						byte_beats[byte_beat_count] = r;
						byte_beat_count++;
						frames_closed++;
						phase_now    = PH_TRAILER;
						trailer_seen = 0;
						held_escapes = 0;
					end
				end else begin
					// Escapes short of a full run turn out to be payload.
					for (i = 0; i < held_escapes && i < RUN_LEN - 1; i++)
						keep_payload(ESC_BYTE);
					keep_payload(b);
					held_escapes = 0;
				end
			end
			default: begin
				if (trailer_seen == 0) begin
					if (b == END_BYTE)
						trailer_seen = 1;
					else
						restart_hunt();
				end else if (trailer_seen < TRAILER_BYTES) begin
					trailer_seen++;
				end else begin
					trailer_seen = 0;
					restart_hunt();
				end
			end
		endcase
		if (byte_beat_count > 0)
			byte_beats[byte_beat_count - 1].last = 1'b1;
		for (i = 0; i < byte_beat_count; i++)
			due_beats.push_back(byte_beats[i]);
	endtask

	task automatic check_beat();
		result_beat_t got;
		result_beat_t want;
		got.kind    = m_tuser;
		got.data    = m_tdata[7:0];
		got.len     = m_tdata[17:8];
		got.version = m_tdata[19:18];
		got.ovf     = m_tdata[20];
		got.last    = m_tlast;
		beats_checked++;
		if (due_beats.size() == 0) begin
			if (mismatches < REPORT_LIMIT)
				$display("[%0t] beat %0d arrived with nothing due: kind %0d data %02h len %0d",
					$time, beats_checked, got.kind, got.data, got.len);
			mismatches++;
		end else begin
			want = due_beats.pop_front();
			if (got.kind !== want.kind || got.data !== want.data || got.len !== want.len ||
			    got.version !== want.version || got.ovf !== want.ovf ||
			    got.last !== want.last) begin
				if (mismatches < REPORT_LIMIT) begin
					$write("[%0t] beat %0d (expected/actual): kind %0d/%0d data %02h/%02h",
						$time, beats_checked, want.kind, got.kind, want.data, got.data);
					$display(" len %0d/%0d version %0d/%0d ovf %0d/%0d last %0d/%0d",
						want.len, got.len, want.version, got.version, want.ovf, got.ovf,
						want.last, got.last);
				end
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_beats.delete();
			restart_hunt();
			hdr_version  = '0;
			hdr_matches  = 0;
			held_escapes = 0;
			trailer_seen = 0;
			kept_bytes   = 0;
			dropped      = 1'b0;
			outstanding  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				deframe_byte(s_tdata);
			end
			if (m_tvalid && m_tready)
				check_beat();
			outstanding = due_beats.size();
		end
	end

endmodule

// File: bench/tb_meter_escape_frame_receiver_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_meter_escape_frame_receiver_unit
// Feeds the frame receiver with a short hand-made byte sequence and then with
// random meter frames, mostly well formed and some damaged, with random gaps
// on the input and random back-pressure on the output. The checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_meter_escape_frame_receiver_unit;
	import mefr_pkg::*;

	typedef enum int {
		FAULT_NONE,
		FAULT_BAD_VERSION,
		FAULT_VERSION_MISMATCH,
		FAULT_NO_END_MARK,
		FAULT_TRUNCATED
	} frame_fault_t;

	localparam int RUN_LEN       = int'(RUN_LAST) + 1;
	localparam int TRAILER_BYTES = 3;
	localparam int ITEM_TARGET   = 450;
	localparam int OVERSIZE      = MAX_LEN + 7;
	localparam int LONG_HOLD     = 150;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;
	wire         m_tuser;
	wire         m_tlast;

	int mismatches;
	int outstanding;
	int beats_checked;
	int frames_closed;
	int bytes_taken;

	int bytes_offered = 0;
	bit src_steady    = 1'b0;
	int holds_wanted  = 0;
	int holds_done    = 0;
	int hold_left     = 0;
	int stall_left    = 0;
	int ready_left    = 0;

	meter_escape_frame_receiver_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	mefr_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.beats_checked (beats_checked),
		.frames_closed (frames_closed),
		.bytes_taken   (bytes_taken)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Output side: runs of readiness and stalls, plus any long hold-off that
	// the stimulus has asked for while it keeps offering bytes.
	always @(posedge clk) begin
		if (hold_left == 0 && holds_done < holds_wanted) begin
			holds_done++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (ready_left > 0) begin
			ready_left--;
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 9) < 7) begin
			ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
			                                         : $urandom_range(1, 8);
			m_tready <= 1'b1;
		end else begin
			stall_left = pick_gap();
			m_tready <= 1'b0;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_offered++;
	endtask

	task automatic send_run(input logic [7:0] b, input int n);
		repeat (n) send_byte(b);
	endtask

	function automatic logic [7:0] random_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Payload with short escape runs; a run never reaches four and the frame
	// body never ends on an escape, so the closing run is seen as such.
	task automatic send_payload(input int len);
		int         esc_run;
		int         i;
		logic [7:0] b;
		esc_run = 0;
		for (i = 0; i < len; i++) begin
			if (esc_run < RUN_LEN - 1 && i != len - 1 && $urandom_range(0, 4) == 0) begin
				b = ESC_BYTE;
			end else begin
				b = random_byte();
				if (b == ESC_BYTE)
					b = 8'hff;
			end
			esc_run = (b == ESC_BYTE) ? esc_run + 1 : 0;
			send_byte(b);
		end
	endtask

	task automatic send_noise(input int n);
		logic [7:0] b;
		int         i;
		for (i = 0; i < n; i++) begin
			b = ($urandom_range(0, 2) == 0) ? ESC_BYTE : random_byte();
			if (i == n - 1 && b == ESC_BYTE)
				b = 8'h00;
			send_byte(b);
		end
	endtask

	task automatic send_frame(input logic [7:0] ver, input int len, input frame_fault_t fault);
		logic [7:0] b;
		int         bad_at;
		int         k;
		send_run(ESC_BYTE, RUN_LEN);
		if (fault == FAULT_BAD_VERSION) begin
			case ($urandom_range(0, 2))
				0: b = ESC_BYTE;
				1: b = 8'h03;
				default: begin
					b = random_byte();
					if (b == VER_ONE || b == VER_TWO)
						b = 8'h00;
				end
			endcase
			send_byte(b);
			return;
		end
		bad_at = (fault == FAULT_VERSION_MISMATCH) ? $urandom_range(1, RUN_LEN - 1) : RUN_LEN;
		for (k = 0; k < RUN_LEN; k++) begin
			if (k == bad_at) begin
				send_byte(ver ^ 8'h03);
				return;
			end
			send_byte(ver);
		end
		send_payload(len);
		if (fault == FAULT_TRUNCATED)
			return;
		send_run(ESC_BYTE, RUN_LEN);
		if (fault == FAULT_NO_END_MARK) begin
			b = random_byte();
			if (b == END_BYTE || $urandom_range(0, 2) == 0)
				b = ESC_BYTE;
		end else begin
			b = END_BYTE;
		end
		send_byte(b);
		// The checksum bytes are skipped unchecked, escapes among them too.
		for (k = 0; k < TRAILER_BYTES; k++)
			send_byte(($urandom_range(0, 3) == 0) ? ESC_BYTE : random_byte());
	endtask

	initial begin
		frame_fault_t fault;
		logic [7:0]   ver;
		int           len;
		bit           oversize_done;
		oversize_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A broken start run, then a frame with extreme bytes and a held run of
		// three escapes flushed by the next byte, then the end mark.
		send_run(ESC_BYTE, 2);
		send_byte(8'h00);
		send_run(ESC_BYTE, RUN_LEN);
		send_run(VER_ONE, RUN_LEN);
		send_byte(8'h00);
		send_byte(8'hff);
		send_run(ESC_BYTE, RUN_LEN - 1);
		send_byte(8'h7f);
		send_run(ESC_BYTE, RUN_LEN);
		send_byte(END_BYTE);
		send_byte(ESC_BYTE);
		send_byte(8'h00);
		send_byte(8'hff);
		// An escape in place of a version byte must not count towards a new
		// start run.
		send_run(ESC_BYTE, RUN_LEN);
		send_byte(ESC_BYTE);
		send_run(ESC_BYTE, RUN_LEN - 1);
		send_byte(VER_TWO);

		while (bytes_offered < ITEM_TARGET + OVERSIZE) begin
			src_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0)
				send_noise($urandom_range(1, 6));
			ver = $urandom_range(0, 1) ? VER_TWO : VER_ONE;
			if (!oversize_done && bytes_offered > 200) begin
				oversize_done = 1'b1;
				holds_wanted++;
				send_frame(ver, OVERSIZE, FAULT_NONE);
			end else begin
				len   = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60)
				                                    : $urandom_range(0, 20);
				fault = ($urandom_range(0, 9) < 7) ? FAULT_NONE
				                                   : frame_fault_t'($urandom_range(1, 4));
				send_frame(ver, len, fault);
			end
		end
		s_tvalid <= 1'b0;
		src_steady = 1'b0;

		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Bytes taken: %0d, result beats checked: %0d, frames closed: %0d.",
			bytes_taken, beats_checked, frames_closed);
		$display("The mix held clean and damaged frames, an oversized frame and a long hold-off.");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
rtl/mefr_pkg.sv
rtl/mefr_front.sv
rtl/mefr_queue.sv
rtl/mefr_back.sv
rtl/meter_escape_frame_receiver_unit.sv
bench/mefr_checker.sv
bench/tb_meter_escape_frame_receiver_unit.sv
